@@ hw/rtl/indexed_array_list_core_defines.svh @@
// Assertion macros shared by the list core modules.
`ifndef INDEXED_ARRAY_LIST_CORE_DEFINES_SVH
`define INDEXED_ARRAY_LIST_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define IAC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define IAC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/iac_pkg.sv @@
package iac_pkg;

    // List geometry.
    localparam int MAX_ITEMS  = 64;
    localparam int ITEM_WIDTH = 32;
    localparam int ADDR_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W      = $clog2(MAX_ITEMS + 1);

    // Field widths on the streams.
    localparam int CMD_W  = 3;
    localparam int POS_W  = 6;
    localparam int DATA_W = 32;
    localparam int LEN_W  = 7;

    // Width used for position and count comparisons.
    localparam int CMP_W = (CNT_W > POS_W + 1) ? CNT_W : POS_W + 1;

    // Stream data widths, padded to whole bytes.
    localparam int S_USED_W  = CMD_W + POS_W + DATA_W;
    localparam int M_USED_W  = 1 + DATA_W + LEN_W + 1;
    localparam int S_TDATA_W = ((S_USED_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((M_USED_W + 7) / 8) * 8;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_GET     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REPLACE = 3'd4;

    // Read address selects.
    localparam logic [1:0] RA_POS     = 2'd0;
    localparam logic [1:0] RA_IDX_DN  = 2'd1;
    localparam logic [1:0] RA_IDX_UP  = 2'd2;

    // Write address and data selects.
    localparam logic [1:0] WA_COUNT = 2'd0;
    localparam logic [1:0] WA_POS   = 2'd1;
    localparam logic [1:0] WA_IDX   = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       capture;
        logic       idx_from_count;
        logic       idx_from_pos;
        logic       idx_inc;
        logic       idx_dec;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       rd_capture;
        logic       rd_clear;
        logic       wr_en;
        logic [1:0] wr_sel;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       res_load;
        logic       res_ok;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             full;
        logic             pos_le_cnt;
        logic             pos_lt_cnt;
        logic             idx_gt_pos;
        logic             idx_next_lt_cnt;
    } dp_sts_t;

endpackage

@@ hw/rtl/iac_ram.sv @@
module iac_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/iac_ctrl.sv @@
`include "indexed_array_list_core_defines.svh"

module iac_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  iac_pkg::dp_sts_t  sts,
    output iac_pkg::dp_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DECODE  = 3'd1;
    localparam logic [2:0] S_INS_CHK = 3'd2;
    localparam logic [2:0] S_INS_WR  = 3'd3;
    localparam logic [2:0] S_REM_CHK = 3'd4;
    localparam logic [2:0] S_REM_WR  = 3'd5;
    localparam logic [2:0] S_GET     = 3'd6;
    localparam logic [2:0] S_RESP    = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       ok_reg, ok_next;
    logic       m_tvalid_reg, m_tvalid_next;

    // Next-state and command decode.
    always_comb begin
        cmd           = '0;
        state_next    = state_reg;
        ok_next       = ok_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd.rd_clear = 1'b1;
                ok_next      = 1'b0;
                state_next   = S_RESP;
                case (sts.cmd)
                    iac_pkg::CMD_APPEND: begin
                        if (!sts.full) begin
                            cmd.wr_en   = 1'b1;
                            cmd.wr_sel  = iac_pkg::WA_COUNT;
                            cmd.cnt_inc = 1'b1;
                            ok_next     = 1'b1;
                        end
                    end
                    iac_pkg::CMD_INSERT: begin
                        if (sts.pos_le_cnt && !sts.full) begin
                            cmd.idx_from_count = 1'b1;
                            state_next         = S_INS_CHK;
                        end
                    end
                    iac_pkg::CMD_REMOVE: begin
                        if (sts.pos_lt_cnt) begin
                            cmd.idx_from_pos = 1'b1;
                            state_next       = S_REM_CHK;
                        end
                    end
                    iac_pkg::CMD_GET: begin
                        if (sts.pos_lt_cnt) begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = iac_pkg::RA_POS;
                            state_next = S_GET;
                        end
                    end
                    iac_pkg::CMD_REPLACE: begin
                        if (sts.pos_lt_cnt) begin
                            cmd.wr_en  = 1'b1;
                            cmd.wr_sel = iac_pkg::WA_POS;
                            ok_next    = 1'b1;
                        end
                    end
                    default: begin
                        ok_next = 1'b0;
                    end
                endcase
            end
            S_INS_CHK: begin
                // Move entries up one place from the end down to the position.
                if (sts.idx_gt_pos) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = iac_pkg::RA_IDX_DN;
                    state_next = S_INS_WR;
                end else begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_sel  = iac_pkg::WA_POS;
                    cmd.cnt_inc = 1'b1;
                    ok_next     = 1'b1;
                    state_next  = S_RESP;
                end
            end
            S_INS_WR: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = iac_pkg::WA_IDX;
                cmd.idx_dec = 1'b1;
                state_next  = S_INS_CHK;
            end
            S_REM_CHK: begin
                // Move entries down one place from the position to the end.
                if (sts.idx_next_lt_cnt) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = iac_pkg::RA_IDX_UP;
                    state_next = S_REM_WR;
                end else begin
                    cmd.cnt_dec = 1'b1;
                    ok_next     = 1'b1;
                    state_next  = S_RESP;
                end
            end
            S_REM_WR: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = iac_pkg::WA_IDX;
                cmd.idx_inc = 1'b1;
                state_next  = S_REM_CHK;
            end
            S_GET: begin
                cmd.rd_capture = 1'b1;
                ok_next        = 1'b1;
                state_next     = S_RESP;
            end
            S_RESP: begin
                // Load the result once the output register is free.
                cmd.res_ok = ok_reg;
                if (!m_tvalid_reg || m_tready) begin
                    cmd.res_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            ok_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ok_reg       <= ok_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    `IAC_ASSERT_NEXT(a_accept_decode, aclk, aresetn, s_tvalid && s_tready, state_reg == S_DECODE, "accepted transfer did not reach decode")
    `IAC_ASSERT_NEXT(a_resp_hold, aclk, aresetn, state_reg == S_RESP && m_tvalid_reg && !m_tready, state_reg == S_RESP && m_tvalid_reg, "pending result overwritten")
    `IAC_ASSERT_NOW(a_valid_from_resp, aclk, aresetn, $rose(m_tvalid_reg), $past(state_reg) == S_RESP, "result raised outside response state")

endmodule

@@ hw/rtl/iac_dp.sv @@
`include "indexed_array_list_core_defines.svh"

module iac_dp (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [iac_pkg::S_TDATA_W-1:0]    s_tdata,
    input  iac_pkg::dp_cmd_t                 cmd,
    output iac_pkg::dp_sts_t                 sts,
    output logic [iac_pkg::M_TDATA_W-1:0]    m_tdata
);

    localparam int POS_LSB  = iac_pkg::CMD_W;
    localparam int ITEM_LSB = iac_pkg::CMD_W + iac_pkg::POS_W;
    localparam int PAD_W    = iac_pkg::M_TDATA_W - iac_pkg::M_USED_W;

    logic [iac_pkg::CMD_W-1:0]      cmd_reg, cmd_next;
    logic [iac_pkg::POS_W-1:0]      pos_reg, pos_next;
    logic [iac_pkg::ITEM_WIDTH-1:0] item_reg, item_next;
    logic [iac_pkg::ADDR_W-1:0]     idx_reg, idx_next;
    logic [iac_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [iac_pkg::ITEM_WIDTH-1:0] rd_item_reg, rd_item_next;
    logic [iac_pkg::M_TDATA_W-1:0]  out_data_reg, out_data_next;

    logic [iac_pkg::CMP_W-1:0]      cnt_x, pos_x, idx_x;
    logic [iac_pkg::ADDR_W-1:0]     ram_raddr, ram_waddr;
    logic [iac_pkg::ITEM_WIDTH-1:0] ram_wdata, ram_rdata;
    logic                           empty;

    // Comparisons for the controller.
    assign cnt_x = iac_pkg::CMP_W'(count_reg);
    assign pos_x = iac_pkg::CMP_W'(pos_reg);
    assign idx_x = iac_pkg::CMP_W'(idx_reg);

    assign sts.cmd             = cmd_reg;
    assign sts.full            = (count_reg == iac_pkg::CNT_W'(iac_pkg::MAX_ITEMS));
    assign sts.pos_le_cnt      = (pos_x <= cnt_x);
    assign sts.pos_lt_cnt      = (pos_x < cnt_x);
    assign sts.idx_gt_pos      = (idx_x > pos_x);
    assign sts.idx_next_lt_cnt = ((idx_x + iac_pkg::CMP_W'(1)) < cnt_x);

    assign empty = (count_reg == '0);

    // Read address select.
    always_comb begin
        case (cmd.rd_sel)
            iac_pkg::RA_IDX_DN: ram_raddr = idx_reg - iac_pkg::ADDR_W'(1);
            iac_pkg::RA_IDX_UP: ram_raddr = idx_reg + iac_pkg::ADDR_W'(1);
            default:            ram_raddr = iac_pkg::ADDR_W'(pos_reg);
        endcase
    end

    // Write address and data select.
    always_comb begin
        case (cmd.wr_sel)
            iac_pkg::WA_COUNT: begin
                ram_waddr = iac_pkg::ADDR_W'(count_reg);
                ram_wdata = item_reg;
            end
            iac_pkg::WA_IDX: begin
                ram_waddr = idx_reg;
                ram_wdata = ram_rdata;
            end
            default: begin
                ram_waddr = iac_pkg::ADDR_W'(pos_reg);
                ram_wdata = item_reg;
            end
        endcase
    end

    // Entry storage.
    iac_ram #(
        .WIDTH (iac_pkg::ITEM_WIDTH),
        .DEPTH (iac_pkg::MAX_ITEMS)
    ) u_ram (
        .clk   (aclk),
        .we    (cmd.wr_en),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_en),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next values of the datapath registers.
    always_comb begin
        cmd_next      = cmd_reg;
        pos_next      = pos_reg;
        item_next     = item_reg;
        idx_next      = idx_reg;
        count_next    = count_reg;
        rd_item_next  = rd_item_reg;
        out_data_next = out_data_reg;

        if (cmd.capture) begin
            cmd_next  = s_tdata[iac_pkg::CMD_W-1:0];
            pos_next  = s_tdata[POS_LSB +: iac_pkg::POS_W];
            item_next = iac_pkg::ITEM_WIDTH'(s_tdata[ITEM_LSB +: iac_pkg::DATA_W]);
        end

        if (cmd.idx_from_count) begin
            idx_next = iac_pkg::ADDR_W'(count_reg);
        end else if (cmd.idx_from_pos) begin
            idx_next = iac_pkg::ADDR_W'(pos_reg);
        end else if (cmd.idx_inc) begin
            idx_next = idx_reg + iac_pkg::ADDR_W'(1);
        end else if (cmd.idx_dec) begin
            idx_next = idx_reg - iac_pkg::ADDR_W'(1);
        end

        if (cmd.cnt_inc) begin
            count_next = count_reg + iac_pkg::CNT_W'(1);
        end else if (cmd.cnt_dec) begin
            count_next = count_reg - iac_pkg::CNT_W'(1);
        end

        if (cmd.rd_clear) begin
            rd_item_next = '0;
        end else if (cmd.rd_capture) begin
            rd_item_next = ram_rdata;
        end

        if (cmd.res_load) begin
            out_data_next = {{PAD_W{1'b0}},
                             empty,
                             iac_pkg::LEN_W'(count_reg),
                             iac_pkg::DATA_W'(rd_item_reg),
                             cmd.res_ok};
        end
    end

    // Item count is the only control state here.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        pos_reg      <= pos_next;
        item_reg     <= item_next;
        idx_reg      <= idx_next;
        rd_item_reg  <= rd_item_next;
        out_data_reg <= out_data_next;
    end

    assign m_tdata = out_data_reg;

    `IAC_ASSERT_NOW(a_rd_wr_excl, aclk, aresetn, cmd.wr_en, !cmd.rd_en, "read and write issued together")
    `IAC_ASSERT_NOW(a_count_max, aclk, aresetn, 1'b1, count_reg <= iac_pkg::CNT_W'(iac_pkg::MAX_ITEMS), "count beyond capacity")
    `IAC_ASSERT_NEXT(a_count_step, aclk, aresetn, 1'b1, count_reg == $past(count_reg) || count_reg == $past(count_reg) + iac_pkg::CNT_W'(1) || count_reg == $past(count_reg) - iac_pkg::CNT_W'(1), "count moved by more than one")

endmodule

@@ hw/rtl/indexed_array_list_core.sv @@
// Indexed list core: an ordered list of up to 64 entries of 32 bits that
// takes one command per input transfer (append, insert at a position,
// remove at a position, get, replace) and returns one result transfer with
// the ok flag, the item read by get, the length afterwards and an empty
// flag. Commands are handled one at a time, and the entry RAM is either
// read or written once per cycle, so the cost is set by that access:
// insert and remove take longer the more entries move, since every
// entry that moves is read and written back through the RAM. A new
// command is accepted once the previous result is in the output
// register, even while that result still waits to be taken.
module indexed_array_list_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [2:0] cmd, [8:3] position, [40:9] item_in, upper bits zero
    input  logic [iac_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] ok, [32:1] item_out, [39:33] length, [40] empty_res, upper bits zero
    output logic [iac_pkg::M_TDATA_W-1:0] m_tdata
);

    iac_pkg::dp_cmd_t dp_cmd;
    iac_pkg::dp_sts_t dp_sts;

    // Sequencer.
    iac_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (dp_sts),
        .cmd      (dp_cmd)
    );

    // Storage, count and result register.
    iac_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .cmd     (dp_cmd),
        .sts     (dp_sts),
        .m_tdata (m_tdata)
    );

endmodule
